/* design/pisc_pkg.sv */
// Package for the PI speed controller with band stop.
// Holds the field widths, register indexes, reset values and the structs
// that pass configuration, state and results between the modules.
package pisc_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned BAND_W  = 15;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned DUTY_W  = 15;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // Register indexes, one per 32-bit word of the configuration space.
    typedef enum logic [2:0] {
        REG_TARGET  = 3'd0,
        REG_BAND    = 3'd1,
        REG_PROP    = 3'd2,
        REG_INTEG   = 3'd3,
        REG_FLOOR   = 3'd4,
        REG_CEILING = 3'd5
    } t_reg_idx;

    localparam logic [SPEED_W-1:0] RST_TARGET  = 16'd1500;
    localparam logic [BAND_W-1:0]  RST_BAND    = 15'd0;
    localparam logic [GAIN_W-1:0]  RST_PROP    = 16'd3277;
    localparam logic [GAIN_W-1:0]  RST_INTEG   = 16'd655;
    localparam logic [DUTY_W-1:0]  RST_FLOOR   = 15'd0;
    localparam logic [DUTY_W-1:0]  RST_CEILING = 15'd25600;

    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic [BAND_W-1:0]  band_half_width;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [DUTY_W-1:0]  duty_floor;
        logic [DUTY_W-1:0]  duty_ceiling;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0] error_sum;
        logic                    reached_flag;
        logic [DUTY_W-1:0]       held_duty;
    } t_state;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_out;
        logic              reached;
    } t_result;

endpackage

/* design/pisc_speed_if.sv */
// Valid/ready channel that carries one measured speed sample per word.
// Depends on pisc_pkg for the field width.
interface pisc_speed_if;
    logic                           valid;
    logic                           ready;
    logic [pisc_pkg::SPEED_W-1:0]   measured_speed;

    modport source (output valid, output measured_speed, input ready);
    modport sink   (input valid, input measured_speed, output ready);
endinterface

/* design/pisc_duty_if.sv */
// Valid/ready channel that carries one duty command and the reached flag per word.
// Depends on pisc_pkg for the field width.
interface pisc_duty_if;
    logic                           valid;
    logic                           ready;
    logic [pisc_pkg::DUTY_W-1:0]    duty_out;
    logic                           reached;

    modport source (output valid, output duty_out, output reached, input ready);
    modport sink   (input valid, input duty_out, input reached, output ready);
endinterface

/* design/pisc_regs.sv */
// APB-style configuration registers of the speed controller.
// Depends on pisc_pkg for register indexes, reset values and the t_cfg struct.
module pisc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pisc_pkg::ADDR_W-1:0] paddr,
    input  logic [pisc_pkg::DATA_W-1:0] pwdata,
    output logic [pisc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pisc_pkg::t_cfg              o_cfg
);

    pisc_pkg::t_cfg   r_cfg;
    pisc_pkg::t_cfg   n_cfg;
    pisc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = pisc_pkg::t_reg_idx'(paddr[pisc_pkg::ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    // Write decode: only the addressed register takes the new value.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                pisc_pkg::REG_TARGET:  n_cfg.target_speed    = pwdata[pisc_pkg::SPEED_W-1:0];
                pisc_pkg::REG_BAND:    n_cfg.band_half_width = pwdata[pisc_pkg::BAND_W-1:0];
                pisc_pkg::REG_PROP:    n_cfg.prop_gain       = pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_INTEG:   n_cfg.integ_gain      = pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_FLOOR:   n_cfg.duty_floor      = pwdata[pisc_pkg::DUTY_W-1:0];
                pisc_pkg::REG_CEILING: n_cfg.duty_ceiling    = pwdata[pisc_pkg::DUTY_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed    <= pisc_pkg::RST_TARGET;
            r_cfg.band_half_width <= pisc_pkg::RST_BAND;
            r_cfg.prop_gain       <= pisc_pkg::RST_PROP;
            r_cfg.integ_gain      <= pisc_pkg::RST_INTEG;
            r_cfg.duty_floor      <= pisc_pkg::RST_FLOOR;
            r_cfg.duty_ceiling    <= pisc_pkg::RST_CEILING;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux, zero-extended to the bus width.
    always_comb begin
        unique case (w_idx)
            pisc_pkg::REG_TARGET:  prdata = pisc_pkg::DATA_W'(r_cfg.target_speed);
            pisc_pkg::REG_BAND:    prdata = pisc_pkg::DATA_W'(r_cfg.band_half_width);
            pisc_pkg::REG_PROP:    prdata = pisc_pkg::DATA_W'(r_cfg.prop_gain);
            pisc_pkg::REG_INTEG:   prdata = pisc_pkg::DATA_W'(r_cfg.integ_gain);
            pisc_pkg::REG_FLOOR:   prdata = pisc_pkg::DATA_W'(r_cfg.duty_floor);
            pisc_pkg::REG_CEILING: prdata = pisc_pkg::DATA_W'(r_cfg.duty_ceiling);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* design/pisc_law.sv */
// Control law of the speed controller: band test, saturating integral,
// PI sum with floor shift, duty clamp and anti-windup. Purely combinational.
// Depends on pisc_pkg for widths and the t_cfg, t_state and t_result structs.
module pisc_law (
    input  logic [pisc_pkg::SPEED_W-1:0] i_meas,
    input  pisc_pkg::t_cfg               i_cfg,
    input  pisc_pkg::t_state             i_state,
    output pisc_pkg::t_state             o_state,
    output pisc_pkg::t_result            o_result
);

    localparam int unsigned ERR_W  = pisc_pkg::SPEED_W + 1;
    localparam int unsigned PP_W   = pisc_pkg::GAIN_W + 1 + ERR_W;
    localparam int unsigned PI_W   = pisc_pkg::GAIN_W + 1 + pisc_pkg::SUM_W;
    localparam int unsigned ACC_W  = PI_W + 1;
    localparam int unsigned DUTY_F = ACC_W - 8;

    logic [ERR_W-1:0]                w_lo_side;
    logic [ERR_W-1:0]                w_hi_bound;
    logic                            w_in_band;
    logic signed [ERR_W-1:0]         w_err;
    logic signed [pisc_pkg::SUM_W:0] w_sum_wide;
    logic signed [pisc_pkg::SUM_W-1:0] w_sum;
    logic signed [PP_W-1:0]          w_prod_p;
    logic signed [PI_W-1:0]          w_prod_i;
    logic signed [ACC_W-1:0]         w_acc;
    logic signed [DUTY_F-1:0]        w_duty;
    logic signed [DUTY_F-1:0]        w_floor;
    logic signed [DUTY_F-1:0]        w_ceiling;

    // Band test without wrap: meas + hw >= target and meas <= target + hw.
    assign w_lo_side  = ERR_W'(i_meas) + ERR_W'(i_cfg.band_half_width);
    assign w_hi_bound = ERR_W'(i_cfg.target_speed) + ERR_W'(i_cfg.band_half_width);
    assign w_in_band  = (w_lo_side >= ERR_W'(i_cfg.target_speed))
                      && (ERR_W'(i_meas) <= w_hi_bound);

    // Error and the saturating integral.
    assign w_err      = $signed(ERR_W'(i_cfg.target_speed)) - $signed(ERR_W'(i_meas));
    assign w_sum_wide = {i_state.error_sum[pisc_pkg::SUM_W-1], i_state.error_sum}
                      + {{(pisc_pkg::SUM_W + 1 - ERR_W){w_err[ERR_W-1]}}, w_err};

    always_comb begin
        if (w_sum_wide[pisc_pkg::SUM_W] != w_sum_wide[pisc_pkg::SUM_W-1]) begin
            w_sum = w_sum_wide[pisc_pkg::SUM_W]
                  ? {1'b1, {(pisc_pkg::SUM_W-1){1'b0}}}
                  : {1'b0, {(pisc_pkg::SUM_W-1){1'b1}}};
        end else begin
            w_sum = w_sum_wide[pisc_pkg::SUM_W-1:0];
        end
    end

    // Two independent multiplies, then the PI sum; dropping eight bits floors.
    assign w_prod_p = $signed({1'b0, i_cfg.prop_gain}) * w_err;
    assign w_prod_i = $signed({1'b0, i_cfg.integ_gain}) * w_sum;
    assign w_acc    = {{(ACC_W-PP_W){w_prod_p[PP_W-1]}}, w_prod_p}
                    + {w_prod_i[PI_W-1], w_prod_i};
    assign w_duty   = w_acc[ACC_W-1:8];

    assign w_floor   = $signed(DUTY_F'(i_cfg.duty_floor));
    assign w_ceiling = $signed(DUTY_F'(i_cfg.duty_ceiling));

    // Latch, hold, or run one control step with clamp and anti-windup.
    always_comb begin
        o_state = i_state;
        if (i_state.reached_flag || w_in_band) begin
            o_state.reached_flag = 1'b1;
            o_result.duty_out    = i_state.held_duty;
            o_result.reached     = 1'b1;
        end else begin
            priority if (w_duty < w_floor) begin
                o_state.held_duty = i_cfg.duty_floor;
            end else if (w_duty > w_ceiling) begin
                o_state.held_duty = i_cfg.duty_ceiling;
            end else begin
                o_state.held_duty = w_duty[pisc_pkg::DUTY_W-1:0];
                o_state.error_sum = w_sum;
            end
            o_result.duty_out = o_state.held_duty;
            o_result.reached  = 1'b0;
        end
    end

endmodule

/* design/pi_speed_controller_with_band_stop.sv */
// Top level of the PI speed controller with band stop.
// Depends on pisc_pkg, pisc_speed_if, pisc_duty_if, pisc_regs and pisc_law.
//
//  Port      Dir   Word                         Handshake
//  i_speed   in    measured_speed[15:0]         valid/ready
//  o_duty    out   duty_out[14:0], reached      valid/ready
//  APB       in    six registers at 4*index     psel/penable/pwrite, pready high
//
// Each word waits in the input register and then lands in the result register;
// the control law and the integral update run as it moves across, so one word
// per cycle is sustained while the output is not stalled, and the result is
// valid once its word has passed the input register and the result register.
// The integral feedback closes through the state register alone.
// Synchronous active-low reset clears the state, the latch and both valids.
// A stalled output holds the result; the input register still takes one word if it is empty.
module pi_speed_controller_with_band_stop (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pisc_speed_if.sink                    i_speed,
    pisc_duty_if.source                   o_duty,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pisc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pisc_pkg::DATA_W-1:0]   pwdata,
    output logic [pisc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    pisc_pkg::t_cfg    w_cfg;
    pisc_pkg::t_state  r_state;
    pisc_pkg::t_state  n_state;
    pisc_pkg::t_result n_result;
    pisc_pkg::t_result r_result;
    logic                         r_in_valid;
    logic [pisc_pkg::SPEED_W-1:0] r_meas;
    logic                         r_out_valid;
    logic                         w_advance;
    logic                         w_take;

    pisc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pisc_law u_law (
        .i_meas   (r_meas),
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Pipeline control: a word moves on when the result register is free or emptying.
    assign w_advance     = r_in_valid && (!r_out_valid || o_duty.ready);
    assign i_speed.ready = !r_in_valid || w_advance;
    assign w_take        = i_speed.valid && i_speed.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_meas <= i_speed.measured_speed;
        end
    end

    // Controller state advances with each word that passes the law.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_duty.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_duty.valid    = r_out_valid;
    assign o_duty.duty_out = r_result.duty_out;
    assign o_duty.reached  = r_result.reached;

endmodule
